// ----- src/rcd_pkg.sv -----
package rcd_pkg;

    // Fixed widths of the stream payload and the configuration data bus.
    localparam int DATA_W         = 64;
    localparam int CFG_W          = 64;
    localparam int REG_PRIME_W    = 32;
    localparam int ADDR_W         = 5;
    localparam int PRIME_BITS_DEF = 32;

    // Register indexes on the configuration port (byte address divided by eight).
    localparam logic [1:0] REG_PRIME_P  = 2'd0;
    localparam logic [1:0] REG_PRIME_Q  = 2'd1;
    localparam logic [1:0] REG_EXPONENT = 2'd2;

    typedef logic [4:0] op_t;

    // Datapath operations. D_* start the shared divider, M_* load the product register.
    localparam op_t OP_NONE    = 5'd0;
    localparam op_t OP_INIT    = 5'd1;
    localparam op_t OP_D_QMODP = 5'd2;
    localparam op_t OP_D_EUC   = 5'd3;
    localparam op_t OP_D_TRED  = 5'd4;
    localparam op_t OP_D_EXP   = 5'd5;
    localparam op_t OP_D_BASE  = 5'd6;
    localparam op_t OP_D_ACC   = 5'd7;
    localparam op_t OP_D_SQ    = 5'd8;
    localparam op_t OP_D_MQP   = 5'd9;
    localparam op_t OP_D_H     = 5'd10;
    localparam op_t OP_M_EUC   = 5'd11;
    localparam op_t OP_M_ACC   = 5'd12;
    localparam op_t OP_M_SQ    = 5'd13;
    localparam op_t OP_M_H     = 5'd14;
    localparam op_t OP_M_OUT   = 5'd15;
    localparam op_t OP_SEL_P   = 5'd16;
    localparam op_t OP_SEL_Q   = 5'd17;
    localparam op_t OP_SHIFT   = 5'd18;
    localparam op_t OP_SAVE_MP = 5'd19;
    localparam op_t OP_SAVE_MQ = 5'd20;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic r1_zero;
        logic r0_one;
        logic e_bit0;
        logic bad_prime;
    } status_t;

endpackage

// ----- src/rcd_divider.sv -----
module rcd_divider #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CW = $clog2(DVD_W);
    localparam logic [CW-1:0] LAST = CW'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] r_reg, r_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // One quotient bit per cycle, restoring form; the partial remainder stays below the divisor.
    always_comb
    begin
        trial     = {r_reg, q_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DVD_W-2:0], fits};
            r_next   = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ----- src/rcd_datapath.sv -----
module rcd_datapath #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rcd_pkg::cmd_t              cmd,
    input  logic [rcd_pkg::DATA_W-1:0] ciphertext,
    input  logic [PRIME_BITS-1:0]      p_cfg,
    input  logic [PRIME_BITS-1:0]      q_cfg,
    input  logic [rcd_pkg::DATA_W-1:0] d_cfg,
    output rcd_pkg::status_t           status,
    output logic [rcd_pkg::DATA_W-1:0] result
);

    localparam int PW = PRIME_BITS;
    localparam int DW = rcd_pkg::DATA_W;

    logic [DW-1:0]   c_reg;
    logic [PW-1:0]   r0_reg, r1_reg, t0_reg, t1_reg, qt_reg, rt_reg;
    logic [PW-1:0]   m_reg, e_reg, b_reg, acc_reg, mp_reg, mq_reg, h_reg;
    logic [2*PW-1:0] prod_reg;
    rcd_pkg::op_t    wb_op_reg;

    logic            div_start;
    logic [DW-1:0]   dvd;
    logic [PW-1:0]   dvs;
    logic            div_done;
    logic [DW-1:0]   quo;
    logic [PW-1:0]   rem;
    logic [PW-1:0]   mul_a, mul_b;
    logic [PW:0]     t_wrap;
    logic [PW-1:0]   t_new;
    logic [PW:0]     h_sum;
    logic [PW-1:0]   h_new;

    rcd_divider #(
        .DVD_W(DW),
        .DVS_W(PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo),
        .remainder(rem)
    );

    // Operand selection for the shared divider.
    always_comb
    begin
        div_start = 1'b1;
        dvd       = DW'(prod_reg);
        dvs       = p_cfg;
        case (cmd.op)
            rcd_pkg::OP_D_QMODP: dvd = DW'(q_cfg);
            rcd_pkg::OP_D_EUC:
            begin
                dvd = DW'(r0_reg);
                dvs = r1_reg;
            end
            rcd_pkg::OP_D_TRED:  dvd = DW'(prod_reg);
            rcd_pkg::OP_D_EXP:
            begin
                dvd = d_cfg;
                dvs = m_reg - 1'b1;
            end
            rcd_pkg::OP_D_BASE:
            begin
                dvd = c_reg;
                dvs = m_reg;
            end
            rcd_pkg::OP_D_ACC,
            rcd_pkg::OP_D_SQ:    dvs = m_reg;
            rcd_pkg::OP_D_MQP:   dvd = DW'(mq_reg);
            rcd_pkg::OP_D_H:     dvd = DW'(prod_reg);
            default:             div_start = 1'b0;
        endcase
    end

    // Operand selection for the multiplier.
    always_comb
    begin
        mul_a = b_reg;
        mul_b = b_reg;
        case (cmd.op)
            rcd_pkg::OP_M_EUC:
            begin
                mul_a = qt_reg;
                mul_b = t1_reg;
            end
            rcd_pkg::OP_M_ACC: mul_a = acc_reg;
            rcd_pkg::OP_M_H:
            begin
                mul_a = h_reg;
                mul_b = t0_reg;
            end
            rcd_pkg::OP_M_OUT:
            begin
                mul_a = h_reg;
                mul_b = q_cfg;
            end
            default:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
        endcase
    end

    // Coefficient update kept modulo p, and the difference of the two residues modulo p.
    always_comb
    begin
        t_wrap = {1'b0, t0_reg} + {1'b0, p_cfg} - {1'b0, rem};
        t_new  = (t0_reg >= rem) ? (t0_reg - rem) : t_wrap[PW-1:0];
        h_sum  = {1'b0, mp_reg} + {1'b0, p_cfg} - {1'b0, rem};
        h_new  = (h_sum >= {1'b0, p_cfg}) ? PW'(h_sum - {1'b0, p_cfg}) : h_sum[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_op_reg <= rcd_pkg::OP_NONE;
        end
        else if (div_start)
        begin
            wb_op_reg <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (wb_op_reg)
                rcd_pkg::OP_D_QMODP: r1_reg <= rem;
                rcd_pkg::OP_D_EUC:
                begin
                    qt_reg <= quo[PW-1:0];
                    rt_reg <= rem;
                end
                rcd_pkg::OP_D_TRED:
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= rt_reg;
                    t0_reg <= t1_reg;
                    t1_reg <= t_new;
                end
                rcd_pkg::OP_D_EXP:   e_reg   <= rem;
                rcd_pkg::OP_D_BASE:  b_reg   <= rem;
                rcd_pkg::OP_D_ACC:   acc_reg <= rem;
                rcd_pkg::OP_D_SQ:    b_reg   <= rem;
                rcd_pkg::OP_D_MQP:   h_reg   <= h_new;
                rcd_pkg::OP_D_H:     h_reg   <= rem;
                default:             r1_reg  <= r1_reg;
            endcase
        end
        case (cmd.op)
            rcd_pkg::OP_INIT:    c_reg <= ciphertext;
            rcd_pkg::OP_D_QMODP:
            begin
                r0_reg <= p_cfg;
                t0_reg <= '0;
                t1_reg <= PW'(1);
            end
            rcd_pkg::OP_D_BASE:  acc_reg <= PW'(1);
            rcd_pkg::OP_M_EUC,
            rcd_pkg::OP_M_ACC,
            rcd_pkg::OP_M_SQ,
            rcd_pkg::OP_M_H,
            rcd_pkg::OP_M_OUT:   prod_reg <= (2*PW)'(mul_a) * (2*PW)'(mul_b);
            rcd_pkg::OP_SEL_P:   m_reg  <= p_cfg;
            rcd_pkg::OP_SEL_Q:   m_reg  <= q_cfg;
            rcd_pkg::OP_SHIFT:   e_reg  <= e_reg >> 1;
            rcd_pkg::OP_SAVE_MP: mp_reg <= acc_reg;
            rcd_pkg::OP_SAVE_MQ: mq_reg <= acc_reg;
            default:             c_reg  <= c_reg;
        endcase
    end

    always_comb
    begin
        status.div_done  = div_done;
        status.r1_zero   = (r1_reg == '0);
        status.r0_one    = (r0_reg == PW'(1));
        status.e_bit0    = e_reg[0];
        status.bad_prime = (p_cfg[PW-1:1] == '0) || (q_cfg[PW-1:1] == '0);
    end

    assign result = DW'(mq_reg) + DW'(prod_reg);

endmodule

// ----- src/rcd_controller.sv -----
module rcd_controller #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_free,
    input  rcd_pkg::status_t status,
    output rcd_pkg::cmd_t    cmd,
    output logic             out_load,
    output logic             out_err
);

    localparam int CW = (PRIME_BITS > 1) ? $clog2(PRIME_BITS) : 1;
    localparam logic [CW-1:0] LAST = CW'(PRIME_BITS - 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_CHECK     = 5'd1;
    localparam logic [4:0] S_QMODP_W   = 5'd2;
    localparam logic [4:0] S_EUC_TEST  = 5'd3;
    localparam logic [4:0] S_EUC_W     = 5'd4;
    localparam logic [4:0] S_EUC_MUL   = 5'd5;
    localparam logic [4:0] S_EUC_RED   = 5'd6;
    localparam logic [4:0] S_EUC_RED_W = 5'd7;
    localparam logic [4:0] S_SEL       = 5'd8;
    localparam logic [4:0] S_EXP       = 5'd9;
    localparam logic [4:0] S_EXP_W     = 5'd10;
    localparam logic [4:0] S_BASE      = 5'd11;
    localparam logic [4:0] S_BASE_W    = 5'd12;
    localparam logic [4:0] S_POW_TEST  = 5'd13;
    localparam logic [4:0] S_ACC_RED   = 5'd14;
    localparam logic [4:0] S_ACC_W     = 5'd15;
    localparam logic [4:0] S_SQ_MUL    = 5'd16;
    localparam logic [4:0] S_SQ_RED    = 5'd17;
    localparam logic [4:0] S_SQ_W      = 5'd18;
    localparam logic [4:0] S_SHIFT     = 5'd19;
    localparam logic [4:0] S_SAVE      = 5'd20;
    localparam logic [4:0] S_MQP       = 5'd21;
    localparam logic [4:0] S_MQP_W     = 5'd22;
    localparam logic [4:0] S_H_MUL     = 5'd23;
    localparam logic [4:0] S_H_RED     = 5'd24;
    localparam logic [4:0] S_H_W       = 5'd25;
    localparam logic [4:0] S_OUT_MUL   = 5'd26;
    localparam logic [4:0] S_DONE      = 5'd27;
    localparam logic [4:0] S_ERR       = 5'd28;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd.op     = rcd_pkg::OP_NONE;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        out_err    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = rcd_pkg::OP_INIT;
                    phase_next = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.bad_prime)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.op     = rcd_pkg::OP_D_QMODP;
                    state_next = S_QMODP_W;
                end
            end
            S_QMODP_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_EUC_TEST;
                end
            end
            S_EUC_TEST:
            begin
                if (status.r1_zero)
                begin
                    state_next = status.r0_one ? S_SEL : S_ERR;
                end
                else
                begin
                    cmd.op     = rcd_pkg::OP_D_EUC;
                    state_next = S_EUC_W;
                end
            end
            S_EUC_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_EUC_MUL;
                end
            end
            S_EUC_MUL:
            begin
                cmd.op     = rcd_pkg::OP_M_EUC;
                state_next = S_EUC_RED;
            end
            S_EUC_RED:
            begin
                cmd.op     = rcd_pkg::OP_D_TRED;
                state_next = S_EUC_RED_W;
            end
            S_EUC_RED_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_EUC_TEST;
                end
            end
            S_SEL:
            begin
                cmd.op     = phase_reg ? rcd_pkg::OP_SEL_Q : rcd_pkg::OP_SEL_P;
                cnt_next   = '0;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.op     = rcd_pkg::OP_D_EXP;
                state_next = S_EXP_W;
            end
            S_EXP_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.op     = rcd_pkg::OP_D_BASE;
                state_next = S_BASE_W;
            end
            S_BASE_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_POW_TEST;
                end
            end
            S_POW_TEST:
            begin
                if (status.e_bit0)
                begin
                    cmd.op     = rcd_pkg::OP_M_ACC;
                    state_next = S_ACC_RED;
                end
                else
                begin
                    state_next = S_SQ_MUL;
                end
            end
            S_ACC_RED:
            begin
                cmd.op     = rcd_pkg::OP_D_ACC;
                state_next = S_ACC_W;
            end
            S_ACC_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL:
            begin
                cmd.op     = rcd_pkg::OP_M_SQ;
                state_next = S_SQ_RED;
            end
            S_SQ_RED:
            begin
                cmd.op     = rcd_pkg::OP_D_SQ;
                state_next = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.op = rcd_pkg::OP_SHIFT;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SAVE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_POW_TEST;
                end
            end
            S_SAVE:
            begin
                if (phase_reg)
                begin
                    cmd.op     = rcd_pkg::OP_SAVE_MQ;
                    phase_next = 1'b0;
                    state_next = S_MQP;
                end
                else
                begin
                    cmd.op     = rcd_pkg::OP_SAVE_MP;
                    phase_next = 1'b1;
                    state_next = S_SEL;
                end
            end
            S_MQP:
            begin
                cmd.op     = rcd_pkg::OP_D_MQP;
                state_next = S_MQP_W;
            end
            S_MQP_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_H_MUL;
                end
            end
            S_H_MUL:
            begin
                cmd.op     = rcd_pkg::OP_M_H;
                state_next = S_H_RED;
            end
            S_H_RED:
            begin
                cmd.op     = rcd_pkg::OP_D_H;
                state_next = S_H_W;
            end
            S_H_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT_MUL;
                end
            end
            S_OUT_MUL:
            begin
                cmd.op     = rcd_pkg::OP_M_OUT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_err    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- src/rsa_crt_decrypt.sv -----
// Every reduction runs through the shared bit-serial divider, so the time from acceptance to a valid
// result grows with the number of Euclid steps and with PRIME_BITS; a degenerate prime is
// rejected before any division starts.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset (rst_n, asynchronous, active low) clears p, q and d to zero, empties the output register
// and returns the controller to idle; with the reset key every request gives key_error = 1.
module rsa_crt_decrypt #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rcd_pkg::DATA_W-1:0]  s_axis_tdata,   // [63:0] ciphertext

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rcd_pkg::DATA_W-1:0]  m_axis_tdata,   // [63:0] plaintext
    output logic                        m_axis_tuser,   // [0] key_error

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcd_pkg::ADDR_W-1:0]  paddr,
    input  logic [rcd_pkg::CFG_W-1:0]   pwdata,
    output logic [rcd_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);

    // Configuration registers. The primes are stored at full register width for read-back;
    // only their low PRIME_BITS bits take part in the arithmetic.
    logic [rcd_pkg::REG_PRIME_W-1:0] prime_p_reg;
    logic [rcd_pkg::REG_PRIME_W-1:0] prime_q_reg;
    logic [rcd_pkg::DATA_W-1:0]      exponent_reg;
    logic [1:0]                      reg_index;
    logic                            cfg_write;

    // Output register: the finished result waits here so that the controller is released.
    logic                        out_valid_reg, out_valid_next;
    logic [rcd_pkg::DATA_W-1:0]  out_data_reg;
    logic                        out_err_reg;

    rcd_pkg::cmd_t               cmd;
    rcd_pkg::status_t            status;
    logic [rcd_pkg::DATA_W-1:0]  result;
    logic                        out_free;
    logic                        out_load;
    logic                        out_err;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg  <= '0;
            prime_q_reg  <= '0;
            exponent_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                rcd_pkg::REG_PRIME_P:  prime_p_reg  <= pwdata[rcd_pkg::REG_PRIME_W-1:0];
                rcd_pkg::REG_PRIME_Q:  prime_q_reg  <= pwdata[rcd_pkg::REG_PRIME_W-1:0];
                rcd_pkg::REG_EXPONENT: exponent_reg <= pwdata;
                default:               exponent_reg <= exponent_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            rcd_pkg::REG_PRIME_P:  prdata = rcd_pkg::CFG_W'(prime_p_reg);
            rcd_pkg::REG_PRIME_Q:  prdata = rcd_pkg::CFG_W'(prime_q_reg);
            rcd_pkg::REG_EXPONENT: prdata = exponent_reg;
            default:               prdata = '0;
        endcase
    end

    // The slot is free when empty or when its present result is being taken this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    rcd_controller #(
        .PRIME_BITS(PRIME_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .out_load (out_load),
        .out_err  (out_err)
    );

    // The datapath holds the working registers, one multiplier with a registered product and
    // the shared divider that performs every reduction and every Euclid quotient.
    rcd_datapath #(
        .PRIME_BITS(PRIME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .ciphertext (s_axis_tdata),
        .p_cfg      (prime_p_reg[PRIME_BITS-1:0]),
        .q_cfg      (prime_q_reg[PRIME_BITS-1:0]),
        .d_cfg      (exponent_reg),
        .status     (status),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // A rejected key gives a zero plaintext with the error flag set.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_err ? '0 : result;
            out_err_reg  <= out_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule
